>>> src/sipq_pkg.sv
// Shared types and codes for the sorted-insertion priority queue.
package sipq_pkg;

	localparam int ID_W   = 16;
	localparam int PRIO_W = 8;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DRAIN  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_ENTRY    = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} fsm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    insert;
		logic    pop;
		logic    emit;
		status_t status;
		logic    last;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_drain;
		logic full;
		logic empty;
		logic one_left;
		logic out_free;
	} dp_stat_t;

endpackage

>>> src/sipq_req_if.sv
// Request channel: operation and entry payload.
interface sipq_req_if import sipq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [ID_W-1:0]   proc_id;
	logic [PRIO_W-1:0] prio;

	modport source (output valid, operation, proc_id, prio, input ready);
	modport sink   (input valid, operation, proc_id, prio, output ready);
endinterface

>>> src/sipq_rsp_if.sv
// Response channel: status and emitted entry.
interface sipq_rsp_if import sipq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ID_W-1:0]   out_id;
	logic [PRIO_W-1:0] out_prio;
	logic              last;

	modport source (output valid, status, out_id, out_prio, last, input ready);
	modport sink   (input valid, status, out_id, out_prio, last, output ready);
endinterface

>>> src/sorted_insert_priority_queue_top.sv
// Sorted-insertion priority queue: a request is latched, then its result goes to the response register.
// Insert: no new request is taken until the last one is done; compare-and-shift over all cells in parallel.
// Drain of N entries: N results, one per cycle while the response register is free, head shifts out.
// A response register held (valid, not ready) stalls the controller; a new request is taken only in idle.
// arst_n clears the fill count, the controller and the response valid; cells keep stale data.
module sorted_insert_priority_queue_top import sipq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	sipq_req_if.sink  req,
	sipq_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sipq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sipq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_op     (req.operation),
		.req_id     (req.proc_id),
		.req_prio   (req.prio),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_id     (rsp.out_id),
		.rsp_prio   (rsp.out_prio),
		.rsp_last   (rsp.last)
	);

endmodule

>>> src/sipq_datapath.sv
// Datapath: sorted entry cells, request latch and response register.
module sipq_datapath import sipq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic              req_op,
	input  logic [ID_W-1:0]   req_id,
	input  logic [PRIO_W-1:0] req_prio,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        rsp_status,
	output logic [ID_W-1:0]   rsp_id,
	output logic [PRIO_W-1:0] rsp_prio,
	output logic              rsp_last
);

	localparam int CW = $clog2(DEPTH + 1);

	logic              op_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] pr_q;
	logic [CW-1:0]     cnt_q;

	logic [ID_W-1:0]   cell_id_q   [DEPTH];
	logic [PRIO_W-1:0] cell_prio_q [DEPTH];
	logic [DEPTH-1:0]  stay;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic              out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req_op;
			id_q <= req_id;
			pr_q <= req_prio;
		end
	end

	// stay[i]: stored entry i stays ahead of the new one. Only a strictly
	// smaller priority passes the head; elsewhere ties go in front.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0)
				stay[i] = (CW'(i) < cnt_q) && !(pr_q < cell_prio_q[i]);
			else
				stay[i] = (CW'(i) < cnt_q) && (pr_q > cell_prio_q[i]);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.insert && !stay[g]) begin
				if (g == 0) begin
					cell_id_q[g]   <= id_q;
					cell_prio_q[g] <= pr_q;
				end else if (stay[(g == 0) ? 0 : g - 1]) begin
					cell_id_q[g]   <= id_q;
					cell_prio_q[g] <= pr_q;
				end else begin
					cell_id_q[g]   <= cell_id_q[(g == 0) ? 0 : g - 1];
					cell_prio_q[g] <= cell_prio_q[(g == 0) ? 0 : g - 1];
				end
			end else if (cmd.pop && (g < DEPTH - 1)) begin
				cell_id_q[g]   <= cell_id_q[(g < DEPTH - 1) ? g + 1 : g];
				cell_prio_q[g] <= cell_prio_q[(g < DEPTH - 1) ? g + 1 : g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.insert) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.status;
			out_last_q   <= cmd.last;
			if (cmd.status == ST_ENTRY) begin
				out_id_q   <= cell_id_q[0];
				out_prio_q <= cell_prio_q[0];
			end else begin
				out_id_q   <= '0;
				out_prio_q <= '0;
			end
		end
	end

	assign stat.op_drain = (op_q == OP_DRAIN);
	assign stat.full     = (cnt_q == CW'(DEPTH));
	assign stat.empty    = (cnt_q == '0);
	assign stat.one_left = (cnt_q == CW'(1));
	assign stat.out_free = !out_valid_q || rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_id     = out_id_q;
	assign rsp_prio   = out_prio_q;
	assign rsp_last   = out_last_q;

endmodule

>>> src/sipq_ctrl.sv
// Controller: sequences insert and drain requests.
module sipq_ctrl import sipq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		cmd.status = ST_INSERTED;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					if (!stat.op_drain) begin
						if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.insert = 1'b1;
							cmd.status = ST_INSERTED;
						end
						state_d = S_IDLE;
					end else if (stat.empty) begin
						cmd.status = ST_EMPTY;
						state_d    = S_IDLE;
					end else begin
						// emit head, shift the rest up
						cmd.pop    = 1'b1;
						cmd.status = ST_ENTRY;
						cmd.last   = stat.one_left;
						if (stat.one_left)
							state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
